FILE: design/column_post_sprite_decoder_top_macros.svh
// Assertion macros for the column-post sprite decoder.
`ifndef COLUMN_POST_SPRITE_DECODER_TOP_MACROS_SVH
`define COLUMN_POST_SPRITE_DECODER_TOP_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define CPSD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked at every rising clock edge, reset included.
`define CPSD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

FILE: design/cpsd_pkg.sv
// Shared constants and types of the column-post sprite decoder.
`timescale 1ns / 1ps
`default_nettype none

package cpsd_pkg;

   // Screen geometry
   localparam int SCREEN_W = 320;
   localparam int SCREEN_H = 200;

   // Bits for a screen column (0..SCREEN_W-1) and a screen row (0..SCREEN_H-1)
   localparam int COL_BITS = $clog2(SCREEN_W + 1);
   localparam int ROW_BITS = $clog2(SCREEN_H + 1);

   // Item kinds on the request channel
   typedef enum logic [1:0] {
      OP_PATCH_START   = 2'd0,
      OP_COLUMN_START  = 2'd1,
      OP_DATA_BYTE     = 2'd2,
      OP_PALETTE_WRITE = 2'd3
   } op_type;

   // Stream markers and fixed values
   localparam logic [7:0] END_OF_COLUMN = 8'hFF;
   localparam logic [7:0] ALPHA_OPAQUE  = 8'hFF;
   localparam logic signed [17:0] TOPDELTA_MAX = 18'sd65535;
   localparam logic signed [17:0] TOPDELTA_RESET = -18'sd1;

endpackage

`default_nettype wire

FILE: design/cpsd_if.sv
// Request and response channel interfaces of the column-post sprite decoder.
`timescale 1ns / 1ps
`default_nettype none

interface cpsd_req_if;
   logic                valid;
   logic                ready;
   cpsd_pkg::op_type    operation;
   logic signed [15:0]  draw_x;
   logic signed [15:0]  draw_y;
   logic signed [15:0]  left_offset;
   logic signed [15:0]  top_offset;
   logic [14:0]         patch_width;
   logic [14:0]         column_index;
   logic [7:0]          data_byte;
   logic [7:0]          palette_index;
   logic [23:0]         palette_color;

   modport source (
      output valid, operation, draw_x, draw_y, left_offset, top_offset,
             patch_width, column_index, data_byte, palette_index, palette_color,
      input  ready
   );
   modport sink (
      input  valid, operation, draw_x, draw_y, left_offset, top_offset,
             patch_width, column_index, data_byte, palette_index, palette_color,
      output ready
   );
endinterface

interface cpsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] write_address;
   logic [31:0] pixel_color;

   modport source (output valid, write_address, pixel_color, input ready);
   modport sink   (input valid, write_address, pixel_color, output ready);
endinterface

`default_nettype wire

FILE: design/column_post_sprite_decoder_top.sv
// Column-post sprite decoder: parses patch/column/post items into pixel writes.
`timescale 1ns / 1ps
`default_nettype none

`include "column_post_sprite_decoder_top_macros.svh"

// Takes one request item per clock, back to back, and turns the column-post
// byte stream into framebuffer writes. Every item is parsed at the edge that
// transfers it; for a visible pixel byte that same edge loads the response
// register with the address and the ARGB color, read through the registered
// port of the 256-entry palette memory, so the write is offered from the next
// cycle on. A new item is taken while a response is being transferred in the
// same cycle, so the rate is one item per clock as long as the response side
// keeps up; req ready drops only while a response sits untaken. The palette
// has no reset and no clearing pass: entries must be written before pixels
// refer to them.
module column_post_sprite_decoder_top (
   input  wire logic   clock,
   input  wire logic   reset,
   cpsd_req_if.sink    req_bus,
   cpsd_rsp_if.source  rsp_bus
);

   // Parse phases of the column stream
   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_COLUMN   = 3'd1,
      PH_TOPDELTA = 3'd2,
      PH_LENGTH   = 3'd3,
      PH_PAD1     = 3'd4,
      PH_PIXELS   = 3'd5,
      PH_PAD2     = 3'd6,
      PH_DONE     = 3'd7
   } phase_type;

   localparam logic signed [17:0] SCREEN_W_S = 18'(cpsd_pkg::SCREEN_W);
   localparam logic signed [17:0] SCREEN_H_S = 18'(cpsd_pkg::SCREEN_H);
   localparam logic signed [16:0] SCREEN_H_S17 = 17'(cpsd_pkg::SCREEN_H);

   // Parse state
   phase_type                         phase_ff, phase_in;
   logic signed [16:0]                origin_x_ff, origin_x_in;
   logic signed [16:0]                origin_y_ff, origin_y_in;
   logic [14:0]                       width_ff, width_in;
   logic [cpsd_pkg::COL_BITS-1:0]     col_x_ff, col_x_in;
   logic signed [17:0]                topdelta_ff, topdelta_in;
   logic signed [17:0]                row_ff, row_in;
   logic [7:0]                        post_left_ff, post_left_in;
   logic [7:0]                        vis_left_ff, vis_left_in;

   // Response register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [15:0]                       addr_ff;
   logic [23:0]                       color_ff;

   // Palette memory
   logic [23:0]                       palette_mem [256];

   logic                              accept;
   logic                              load_out;
   logic signed [17:0]                col_sx;
   logic                              col_visible;
   logic signed [17:0]                byte_s;
   logic signed [17:0]                td_sum;
   logic signed [17:0]                post_row;
   logic [31:0]                       addr_full;

   // Handshake: response register frees up when empty or being transferred
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.write_address = addr_ff;
   assign rsp_bus.pixel_color   = {cpsd_pkg::ALPHA_OPAQUE, color_ff};

   // Column selection
   always_comb begin
      col_sx = $signed({origin_x_ff[16], origin_x_ff})
             + $signed({3'b000, req_bus.column_index});
      col_visible = (req_bus.column_index < width_ff) && !col_sx[17]
                 && (col_sx < SCREEN_W_S) && (origin_y_ff < SCREEN_H_S17);
   end

   // Post top with the tall-patch rule and saturation
   always_comb begin
      byte_s = $signed({10'd0, req_bus.data_byte});
      if (byte_s <= topdelta_ff) begin
         td_sum = topdelta_ff + byte_s;
      end else begin
         td_sum = byte_s;
      end
      if (td_sum > cpsd_pkg::TOPDELTA_MAX) begin
         td_sum = cpsd_pkg::TOPDELTA_MAX;
      end
      post_row = $signed({origin_y_ff[16], origin_y_ff}) + td_sum;
   end

   // A pixel byte makes a write when rows are left and the row is on screen
   assign load_out = accept && (req_bus.operation == cpsd_pkg::OP_DATA_BYTE)
                  && (phase_ff == PH_PIXELS) && (vis_left_ff != 8'd0) && !row_ff[17];

   assign addr_full = 32'(col_x_ff)
                    + 32'(row_ff[cpsd_pkg::ROW_BITS-1:0]) * 32'(cpsd_pkg::SCREEN_W);

   // Next parse state
   always_comb begin
      phase_in     = phase_ff;
      origin_x_in  = origin_x_ff;
      origin_y_in  = origin_y_ff;
      width_in     = width_ff;
      col_x_in     = col_x_ff;
      topdelta_in  = topdelta_ff;
      row_in       = row_ff;
      post_left_in = post_left_ff;
      vis_left_in  = vis_left_ff;
      if (accept) begin
         unique case (req_bus.operation)
            cpsd_pkg::OP_PATCH_START: begin
               origin_x_in = $signed({req_bus.draw_x[15], req_bus.draw_x})
                           - $signed({req_bus.left_offset[15], req_bus.left_offset});
               origin_y_in = $signed({req_bus.draw_y[15], req_bus.draw_y})
                           - $signed({req_bus.top_offset[15], req_bus.top_offset});
               width_in    = req_bus.patch_width;
               phase_in    = PH_COLUMN;
            end
            cpsd_pkg::OP_COLUMN_START: begin
               col_x_in     = col_visible ? col_sx[cpsd_pkg::COL_BITS-1:0] : '0;
               topdelta_in  = cpsd_pkg::TOPDELTA_RESET;
               row_in       = '0;
               post_left_in = '0;
               vis_left_in  = '0;
               phase_in     = col_visible ? PH_TOPDELTA : PH_DONE;
            end
            cpsd_pkg::OP_PALETTE_WRITE: begin
               // handled by the palette memory
            end
            cpsd_pkg::OP_DATA_BYTE: begin
               unique case (phase_ff)
                  PH_TOPDELTA: begin
                     if (req_bus.data_byte == cpsd_pkg::END_OF_COLUMN) begin
                        phase_in = PH_DONE;
                     end else begin
                        topdelta_in = td_sum;
                        row_in      = post_row;
                        phase_in    = (post_row >= SCREEN_H_S) ? PH_DONE : PH_LENGTH;
                     end
                  end
                  PH_LENGTH: begin
                     // clip the post at the bottom of the screen
                     post_left_in = req_bus.data_byte;
                     if (row_ff + byte_s > SCREEN_H_S) begin
                        vis_left_in = 8'(SCREEN_H_S - row_ff);
                     end else begin
                        vis_left_in = req_bus.data_byte;
                     end
                     phase_in = PH_PAD1;
                  end
                  PH_PAD1: begin
                     phase_in = (post_left_ff != 8'd0) ? PH_PIXELS : PH_PAD2;
                  end
                  PH_PIXELS: begin
                     if (vis_left_ff != 8'd0) begin
                        vis_left_in = vis_left_ff - 8'd1;
                     end
                     row_in       = row_ff + 18'sd1;
                     post_left_in = post_left_ff - 8'd1;
                     if (post_left_ff == 8'd1) begin
                        phase_in = PH_PAD2;
                     end
                  end
                  PH_PAD2: begin
                     phase_in = PH_TOPDELTA;
                  end
                  PH_IDLE, PH_COLUMN, PH_DONE: begin
                     // bytes outside a column are dropped
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   // Response valid: set by a pixel write, cleared by a transfer
   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         width_ff     <= '0;
         col_x_ff     <= '0;
         topdelta_ff  <= cpsd_pkg::TOPDELTA_RESET;
         row_ff       <= '0;
         post_left_ff <= '0;
         vis_left_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         origin_x_ff  <= origin_x_in;
         origin_y_ff  <= origin_y_in;
         width_ff     <= width_in;
         col_x_ff     <= col_x_in;
         topdelta_ff  <= topdelta_in;
         row_ff       <= row_in;
         post_left_ff <= post_left_in;
         vis_left_ff  <= vis_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload, with the palette read on the same edge
   always_ff @(posedge clock) begin
      if (load_out) begin
         addr_ff  <= addr_full[15:0];
         color_ff <= palette_mem[req_bus.data_byte];
      end
   end

   // Palette writes
   always_ff @(posedge clock) begin
      if (accept && (req_bus.operation == cpsd_pkg::OP_PALETTE_WRITE)) begin
         palette_mem[req_bus.palette_index] <= req_bus.palette_color;
      end
   end

   // Checks
   `CPSD_ASSERT(a_pixels_have_bytes, (phase_ff == PH_PIXELS) |-> (post_left_ff != 8'd0), "pixel phase with no bytes left")
   `CPSD_ASSERT(a_visible_within_post, vis_left_ff <= post_left_ff, "visible rows exceed post length")
   `CPSD_ASSERT(a_pixel_from_data, (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(phase_ff == PH_PIXELS), "response not caused by a pixel byte")
   `CPSD_ASSERT_ALWAYS(a_no_overrun, (rsp_bus.valid && !rsp_bus.ready) |-> !req_bus.ready, "request taken while response stalled")

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Testbench for the column-post sprite decoder: predicted pixel writes vs. response transfers.
`timescale 1ns / 1ps

module tb;

   localparam int RANDOM_ITEMS = 300;
   localparam int DRAIN_EVERY  = 200;

   // Parser position within the column stream
   typedef enum logic [2:0] {
      PARSE_IDLE,
      PARSE_COLUMN,
      PARSE_TOPDELTA,
      PARSE_LENGTH,
      PARSE_PAD1,
      PARSE_PIXELS,
      PARSE_PAD2,
      PARSE_DONE
   } parse_state_type;

   typedef struct {
      cpsd_pkg::op_type   op;
      logic signed [15:0] draw_x;
      logic signed [15:0] draw_y;
      logic signed [15:0] left_offset;
      logic signed [15:0] top_offset;
      logic [14:0]        patch_width;
      logic [14:0]        column_index;
      logic [7:0]         data_byte;
      logic [7:0]         palette_index;
      logic [23:0]        palette_color;
   } sprite_item_type;

   typedef struct packed {
      logic [15:0] addr;
      logic [31:0] color;
   } pixel_write_type;

   logic clock;
   logic reset;

   cpsd_req_if req_bus ();
   cpsd_rsp_if rsp_bus ();

   column_post_sprite_decoder_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Decoder state as predicted from the accepted items
   parse_state_type parse_state = PARSE_IDLE;
   int              org_x       = 0;
   int              org_y       = 0;
   logic [14:0]     patch_cols  = '0;
   int              col_x       = 0;
   bit              col_visible = 0;
   int              run_td      = -1;
   int              cur_row     = 0;
   int              post_left   = 0;
   int              rows_left   = 0;
   logic [23:0]     palette_mirror [256];

   pixel_write_type pending_writes [$];
   int              items_used = 0;
   int              err_count  = 0;
   bit              stall_en   = 1'b1;

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("** column_post_sprite_decoder_top: FAILED **");
      $finish;
   end

   task automatic report_mismatch(input string what);
      err_count++;
      $display("%0t: mismatch: %s", $time, what);
   endtask

   // Advance the predicted state by one item; queue the pixel write it causes
   function automatic void decode_item(input sprite_item_type it);
      int              sx;
      int              cnt;
      logic [31:0]     addr;
      pixel_write_type wr;
      case (it.op)
         cpsd_pkg::OP_PATCH_START: begin
            org_x       = int'(it.draw_x) - int'(it.left_offset);
            org_y       = int'(it.draw_y) - int'(it.top_offset);
            patch_cols  = it.patch_width;
            parse_state = PARSE_COLUMN;
         end
         cpsd_pkg::OP_COLUMN_START: begin
            sx          = org_x + int'(it.column_index);
            col_visible = (it.column_index < patch_cols) && (sx >= 0) &&
                          (sx < cpsd_pkg::SCREEN_W) && (org_y < cpsd_pkg::SCREEN_H);
            col_x       = col_visible ? sx : 0;
            run_td      = -1;
            cur_row     = 0;
            post_left   = 0;
            rows_left   = 0;
            parse_state = col_visible ? PARSE_TOPDELTA : PARSE_DONE;
         end
         cpsd_pkg::OP_PALETTE_WRITE: begin
            palette_mirror[it.palette_index] = it.palette_color;
         end
         default: begin
            case (parse_state)
               PARSE_TOPDELTA: begin
                  if (it.data_byte == cpsd_pkg::END_OF_COLUMN) begin
                     parse_state = PARSE_DONE;
                  end else begin
                     // tall patch: a topdelta not above the running one is relative
                     if (int'(it.data_byte) <= run_td) run_td += int'(it.data_byte);
                     else run_td = int'(it.data_byte);
                     if (run_td > 65535) run_td = 65535;
                     cur_row     = org_y + run_td;
                     parse_state = (cur_row >= cpsd_pkg::SCREEN_H) ? PARSE_DONE
                                                                   : PARSE_LENGTH;
                  end
               end
               PARSE_LENGTH: begin
                  cnt = int'(it.data_byte);
                  if (cur_row + cnt > cpsd_pkg::SCREEN_H) cnt = cpsd_pkg::SCREEN_H - cur_row;
                  post_left   = int'(it.data_byte);
                  rows_left   = cnt;
                  parse_state = PARSE_PAD1;
               end
               PARSE_PAD1: begin
                  parse_state = (post_left != 0) ? PARSE_PIXELS : PARSE_PAD2;
               end
               PARSE_PIXELS: begin
                  if (rows_left > 0) begin
                     // rows above the screen use up a row but write nothing
                     if (cur_row >= 0) begin
                        addr     = 32'(col_x + cur_row * cpsd_pkg::SCREEN_W);
                        wr.addr  = addr[15:0];
                        wr.color = {cpsd_pkg::ALPHA_OPAQUE, palette_mirror[it.data_byte]};
                        pending_writes.push_back(wr);
                     end
                     rows_left--;
                  end
                  cur_row++;
                  post_left--;
                  if (post_left == 0) parse_state = PARSE_PAD2;
               end
               PARSE_PAD2: begin
                  parse_state = PARSE_TOPDELTA;
               end
               default: ;
            endcase
         end
      endcase
   endfunction

   // Compare each response transfer with the oldest predicted write
   always @(posedge clock) begin : check_writes
      pixel_write_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_writes.size() == 0) begin
            report_mismatch($sformatf("unexpected write addr=%0d color=%08h",
                                      rsp_bus.write_address, rsp_bus.pixel_color));
         end else begin
            want = pending_writes.pop_front();
            if (rsp_bus.write_address !== want.addr)
               report_mismatch($sformatf("write_address %0d, expected %0d",
                                         rsp_bus.write_address, want.addr));
            if (rsp_bus.pixel_color !== want.color)
               report_mismatch($sformatf("pixel_color %08h, expected %08h (addr %0d)",
                                         rsp_bus.pixel_color, want.color, want.addr));
         end
      end
   end

   // Response side: ready in random bursts
   initial begin : drive_rsp_ready
      int hold;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         hold = $urandom_range(1, 19);
         rsp_bus.ready <= !(stall_en && $urandom_range(0, 2) == 0);
         repeat (hold) @(posedge clock);
      end
   end

   function automatic sprite_item_type rand_item();
      sprite_item_type it;
      it.op            = cpsd_pkg::op_type'($urandom_range(0, 3));
      it.draw_x        = 16'($urandom);
      it.draw_y        = 16'($urandom);
      it.left_offset   = 16'($urandom);
      it.top_offset    = 16'($urandom);
      it.patch_width   = 15'($urandom);
      it.column_index  = 15'($urandom);
      it.data_byte     = 8'($urandom);
      it.palette_index = 8'($urandom);
      it.palette_color = 24'($urandom);
      return it;
   endfunction

   // One request transfer, with an occasional idle burst before it
   task automatic send_item(input sprite_item_type it);
      if (stall_en && $urandom_range(0, 9) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.operation     <= it.op;
      req_bus.draw_x        <= it.draw_x;
      req_bus.draw_y        <= it.draw_y;
      req_bus.left_offset   <= it.left_offset;
      req_bus.top_offset    <= it.top_offset;
      req_bus.patch_width   <= it.patch_width;
      req_bus.column_index  <= it.column_index;
      req_bus.data_byte     <= it.data_byte;
      req_bus.palette_index <= it.palette_index;
      req_bus.palette_color <= it.palette_color;
      do @(posedge clock); while (!req_bus.ready);
      // bytes the parser drops do not count as useful stimulus
      if (it.op != cpsd_pkg::OP_DATA_BYTE ||
          !(parse_state inside {PARSE_IDLE, PARSE_COLUMN, PARSE_DONE}))
         items_used++;
      decode_item(it);
   endtask

   task automatic send_patch(input int dx, input int dy, input int lo, input int to,
                             input int cols);
      sprite_item_type it;
      it             = rand_item();
      it.op          = cpsd_pkg::OP_PATCH_START;
      it.draw_x      = 16'(dx);
      it.draw_y      = 16'(dy);
      it.left_offset = 16'(lo);
      it.top_offset  = 16'(to);
      it.patch_width = 15'(cols);
      send_item(it);
   endtask

   task automatic send_column(input int idx);
      sprite_item_type it;
      it              = rand_item();
      it.op           = cpsd_pkg::OP_COLUMN_START;
      it.column_index = 15'(idx);
      send_item(it);
   endtask

   task automatic send_byte(input int b);
      sprite_item_type it;
      it           = rand_item();
      it.op        = cpsd_pkg::OP_DATA_BYTE;
      it.data_byte = 8'(b);
      send_item(it);
   endtask

   task automatic send_palette(input int idx, input int rgb);
      sprite_item_type it;
      it               = rand_item();
      it.op            = cpsd_pkg::OP_PALETTE_WRITE;
      it.palette_index = 8'(idx);
      it.palette_color = 24'(rgb);
      send_item(it);
   endtask

   // One post: topdelta, length, pad, pixel bytes, pad
   task automatic send_post(input int td, input int len);
      send_byte(td);
      send_byte(len);
      send_byte($urandom);
      repeat (len) send_byte($urandom);
      send_byte($urandom);
   endtask

   // Hold off the request side until every predicted write has come out
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Whole palette first, so no pixel can read an unwritten entry
   task automatic test_palette_load();
      for (int i = 0; i < 256; i++)
         send_palette(i, (i == 0) ? 0 : (i == 255) ? 24'hFF_FFFF : $urandom);
   endtask

   // Stream bytes with no column open, and a column with no patch
   task automatic test_stray_bytes();
      send_byte(8'h00);
      send_byte(cpsd_pkg::END_OF_COLUMN);
      send_column(0);
      send_post(0, 2);
      send_byte(cpsd_pkg::END_OF_COLUMN);
   endtask

   // Column visibility at the patch width and the screen sides
   task automatic test_column_edges();
      send_patch(0, 0, 0, 0, 2);
      send_byte(8'h05);
      send_column(1);
      send_post(0, 1);
      send_post(0, 1);           // tall patch: same row again
      send_byte(cpsd_pkg::END_OF_COLUMN);
      send_byte(8'h00);          // after the end marker
      send_column(2);            // index equal to width
      send_post(0, 1);
      send_patch(319, 0, 0, 0, 2);
      send_column(0);            // rightmost screen column
      send_post(3, 1);
      send_byte(cpsd_pkg::END_OF_COLUMN);
      send_column(1);            // one past the right edge
      send_post(0, 1);
      send_patch(32767, -32768, -32768, 32767, 32767);
      send_column(32767);
      send_post(0, 1);
      send_patch(-32768, 32767, 32767, -32768, 1);
      send_column(0);
      send_post(0, 1);
   endtask

   // Rows above the screen, bottom clip, post at the bottom, patch below
   task automatic test_row_clipping();
      send_patch(10, -3, 0, 0, 1);
      send_column(0);
      send_post(0, 5);
      send_post(8, 0);
      send_byte(cpsd_pkg::END_OF_COLUMN);
      send_patch(20, 190, 0, -8, 1);
      send_column(0);
      send_post(0, 4);
      send_post(5, 1);           // top row past the bottom ends the column
      send_post(0, 1);
      send_patch(30, 200, 0, 0, 1);
      send_column(0);
      send_post(0, 1);
      send_patch(40, 0, 0, 0, 1);
      send_column(0);
      send_post(0, 255);
      send_byte(cpsd_pkg::END_OF_COLUMN);
   endtask

   // Mostly well-formed sprites with random content, plus noise
   task automatic test_random_sprites();
      int base;
      int next_drain;
      int kind;
      int dx, dy, lo, to, w;
      int len;
      base       = items_used;
      next_drain = DRAIN_EVERY;
      while (items_used - base < RANDOM_ITEMS) begin
         if (items_used - base > RANDOM_ITEMS - 150) stall_en = 1'b0;
         if (items_used - base >= next_drain) begin
            wait_for_drain();
            next_drain += DRAIN_EVERY;
         end
         kind = $urandom_range(0, 99);
         if (kind < 6) begin
            send_palette($urandom, $urandom);
         end else if (kind < 12) begin
            send_item(rand_item());
         end else if (kind < 17) begin
            // column cut short
            send_column($urandom_range(0, 3));
            repeat ($urandom_range(0, 6)) send_byte($urandom);
         end else begin
            dx = ($urandom_range(0, 9) == 0) ? $urandom : int'($urandom_range(0, 400)) - 40;
            dy = ($urandom_range(0, 9) == 0) ? $urandom : int'($urandom_range(0, 260)) - 40;
            lo = ($urandom_range(0, 9) == 0) ? $urandom : int'($urandom_range(0, 40)) - 20;
            to = ($urandom_range(0, 9) == 0) ? $urandom : int'($urandom_range(0, 40)) - 20;
            w  = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 6);
            send_patch(dx, dy, lo, to, w);
            repeat ($urandom_range(1, 3)) begin
               send_column(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 7));
               repeat ($urandom_range(0, 3)) begin
                  len = ($urandom_range(0, 29) == 0) ? $urandom_range(100, 255)
                                                     : $urandom_range(0, 10);
                  send_post($urandom_range(0, 60), len);
               end
               if ($urandom_range(0, 9) != 0) send_byte(cpsd_pkg::END_OF_COLUMN);
            end
         end
      end
   endtask

   // Sequence
   initial begin
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.operation     <= cpsd_pkg::OP_PATCH_START;
      req_bus.draw_x        <= '0;
      req_bus.draw_y        <= '0;
      req_bus.left_offset   <= '0;
      req_bus.top_offset    <= '0;
      req_bus.patch_width   <= '0;
      req_bus.column_index  <= '0;
      req_bus.data_byte     <= '0;
      req_bus.palette_index <= '0;
      req_bus.palette_color <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_stray_bytes();
      test_palette_load();
      test_column_edges();
      test_row_clipping();
      test_random_sprites();

      req_bus.valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (err_count == 0) begin
         $display("** column_post_sprite_decoder_top: PASSED **");
      end else begin
         $display("** column_post_sprite_decoder_top: FAILED **");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+design
design/cpsd_pkg.sv
design/cpsd_if.sv
design/column_post_sprite_decoder_top.sv
tb/sv/tb.sv
